/* design/rfc_pkg.sv */
// ----------------------------------------------------------------------------
// Remote frame checker package
// Shared constants and types for the packet checker front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  // Packet geometry.
  localparam int unsigned PayloadBytes = 32;
  localparam int unsigned PosW         = 6;
  localparam int unsigned SumW         = 14;
  localparam int unsigned CsumW        = 32;
  localparam int unsigned FieldFirst   = 2;
  localparam int unsigned FieldCount   = 11;

  localparam logic [PosW-1:0] PosHdr0     = PosW'(0);
  localparam logic [PosW-1:0] PosHdr1     = PosW'(1);
  localparam logic [PosW-1:0] PosFieldLo  = PosW'(FieldFirst);
  localparam logic [PosW-1:0] PosFieldHi  = PosW'(FieldFirst + FieldCount - 1);
  localparam logic [PosW-1:0] PosSumEnd   = PosW'(PayloadBytes - 4);
  localparam logic [PosW-1:0] PosLast     = PosW'(PayloadBytes - 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHeaderFirst  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgHeaderSecond = CfgIdxW'(1);

  localparam logic [7:0] HeaderFirstReset  = 8'd170;
  localparam logic [7:0] HeaderSecondReset = 8'd85;

  // Result queue depth.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
  } rfc_cfg_t;

  // One finished packet as seen by the front: check result plus raw bytes.
  typedef struct packed {
    logic                        ok;
    logic [FieldCount-1:0][7:0]  fields;
  } rfc_result_t;

endpackage

`default_nettype wire

/* design/rfc_front.sv */
// ----------------------------------------------------------------------------
// Remote frame checker front end
// Tracks byte position, header match and sums; emits one check record
// per completed packet.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 start_of_packet_i,
  input  wire rfc_pkg::rfc_cfg_t    cfg_i,
  output logic                      push_o,
  output rfc_pkg::rfc_result_t      result_o
);
  import rfc_pkg::*;

  logic [PosW-1:0]             pos_q, pos_d, pos_eff;
  logic [SumW-1:0]             sum_q, sum_d;
  logic                        hdr_ok_q, hdr_ok_d;
  logic [CsumW-1:0]            csum_q, csum_d;
  logic [FieldCount-1:0][7:0]  field_q;
  logic [3:0]                  field_idx;
  logic                        is_last;

  assign pos_eff   = start_of_packet_i ? PosHdr0 : pos_q;
  assign is_last   = (pos_eff == PosLast);
  assign field_idx = 4'(pos_eff - PosFieldLo);

  always_comb begin
    sum_d    = sum_q;
    hdr_ok_d = hdr_ok_q;
    csum_d   = csum_q;
    if (pos_eff == PosHdr0) begin
      hdr_ok_d = (data_byte_i == cfg_i.header_first);
      sum_d    = SumW'(data_byte_i);
      csum_d   = '0;
    end else begin
      if (pos_eff == PosHdr1) begin
        hdr_ok_d = hdr_ok_q & (data_byte_i == cfg_i.header_second);
      end
      if (pos_eff < PosSumEnd) begin
        sum_d = sum_q + SumW'(data_byte_i);
      end else begin
        csum_d = {csum_q[CsumW-9:0], data_byte_i};
      end
    end
    pos_d = is_last ? PosHdr0 : pos_eff + PosW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      hdr_ok_q <= 1'b1;
      csum_q   <= '0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      hdr_ok_q <= hdr_ok_d;
      csum_q   <= csum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pos_eff >= PosFieldLo && pos_eff <= PosFieldHi) begin
      field_q[field_idx] <= data_byte_i;
    end
  end

  // On the last byte the checksum is complete once this byte is shifted in;
  // the running sum stopped growing four bytes earlier.
  assign push_o          = accept_i & is_last;
  assign result_o.ok     = hdr_ok_q & (csum_d == CsumW'(sum_q));
  assign result_o.fields = field_q;

endmodule

`default_nettype wire

/* design/rfc_queue.sv */
// ----------------------------------------------------------------------------
// Remote frame checker result queue
// Two-entry FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire rfc_pkg::rfc_result_t wdata_i,
  input  wire logic                 pop_i,
  output rfc_pkg::rfc_result_t      rdata_o,
  output logic                      full_o,
  output logic                      empty_o
);
  import rfc_pkg::*;

  rfc_result_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QueueCntW'(1);
      2'b01:   cnt_d = cnt_q - QueueCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QueuePtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + QueuePtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* design/rfc_back.sv */
// ----------------------------------------------------------------------------
// Remote frame checker back end
// Unpacks check records into command fields and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire rfc_pkg::rfc_result_t q_data_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      frame_ok_o,
  output logic [15:0]               yaw_cmd_o,
  output logic [15:0]               throttle_cmd_o,
  output logic [15:0]               pitch_cmd_o,
  output logic [15:0]               roll_cmd_o,
  output logic [7:0]                shutdown_cmd_o,
  output logic [7:0]                hold_height_cmd_o,
  output logic [7:0]                unlock_cmd_o
);
  import rfc_pkg::*;

  logic                       valid_q;
  logic [FieldCount-1:0][7:0] f;

  assign q_pop_o     = !q_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;

  // A failed packet reports all fields as zero.
  assign f = q_data_i.ok ? q_data_i.fields : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      frame_ok_o        <= q_data_i.ok;
      yaw_cmd_o         <= {f[0], f[1]};
      throttle_cmd_o    <= {f[2], f[3]};
      pitch_cmd_o       <= {f[4], f[5]};
      roll_cmd_o        <= {f[6], f[7]};
      shutdown_cmd_o    <= f[8];
      hold_height_cmd_o <= f[9];
      unlock_cmd_o      <= f[10];
    end
  end

endmodule

`default_nettype wire

/* design/remote_frame_checker.sv */
// ----------------------------------------------------------------------------
// Remote frame checker
// Checks fixed-length control packets byte by byte and unpacks the commands.
// ----------------------------------------------------------------------------
// Usage: packet bytes arrive on the input valid/ready channel, one request per
// byte, with start_of_packet_i marking byte zero. A start flag in the middle
// of a packet drops that packet silently. After the last of the 32 bytes the
// position wraps, so back-to-back packets need no start flag.
// Each completed packet yields one request on the output channel carrying
// frame_ok_o and the stick and command fields; the fields read zero when the
// header or the trailing big-endian checksum does not match.
// Throughput is one byte per cycle while the result queue has room, set by
// the single add-and-compare step in the front end. A check record enters
// the result queue when its packet's last byte is accepted and moves into
// the output register when the back end pops the queue.
// When the receiver stalls, results collect in the two-entry queue; input
// ready drops only when the queue is full, and then only a packet's last
// byte would actually need the space.
// Reset clears the position, the sums, the queue and the output valid, and
// loads the header registers with 170 and 85. Configuration writes take
// effect at the next clock edge and should be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_frame_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration write port.
  input  wire logic                        cfg_we_i,
  input  wire logic [rfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]                  cfg_wdata_i,
  // Byte input channel.
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        start_of_packet_i,
  // Result output channel.
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             frame_ok_o,
  output logic [15:0]                      yaw_cmd_o,
  output logic [15:0]                      throttle_cmd_o,
  output logic [15:0]                      pitch_cmd_o,
  output logic [15:0]                      roll_cmd_o,
  output logic [7:0]                       shutdown_cmd_o,
  output logic [7:0]                       hold_height_cmd_o,
  output logic [7:0]                       unlock_cmd_o
);
  import rfc_pkg::*;

  rfc_cfg_t    cfg_q;
  rfc_result_t front_result, q_data;
  logic        accept, push, pop, q_full, q_empty;

  // Header registers; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstReset;
      cfg_q.header_second <= HeaderSecondReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeaderFirst:  cfg_q.header_first  <= cfg_wdata_i;
        CfgHeaderSecond: cfg_q.header_second <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The front accepts any byte while the queue has room for a result.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  rfc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .start_of_packet_i (start_of_packet_i),
    .cfg_i             (cfg_q),
    .push_o            (push),
    .result_o          (front_result)
  );

  rfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_result),
    .pop_i   (pop),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rfc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_data),
    .q_pop_o           (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_ok_o        (frame_ok_o),
    .yaw_cmd_o         (yaw_cmd_o),
    .throttle_cmd_o    (throttle_cmd_o),
    .pitch_cmd_o       (pitch_cmd_o),
    .roll_cmd_o        (roll_cmd_o),
    .shutdown_cmd_o    (shutdown_cmd_o),
    .hold_height_cmd_o (hold_height_cmd_o),
    .unlock_cmd_o      (unlock_cmd_o)
  );

endmodule

`default_nettype wire

/* test/remote_frame_checker_tb.sv */
// ----------------------------------------------------------------------------
// Remote frame checker testbench
// Drives packet bytes with random gaps and random result back-pressure. Each
// accepted byte goes into a scoreboard that tracks the packet position, header
// match and checksum, and queues the result the finished packet should give.
// Every result on the output channel is compared field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_frame_checker_tb;

  import rfc_pkg::*;

  // Register indexes past the two header registers; the block ignores them.
  localparam logic [CfgIdxW-1:0] CfgUnused2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgUnused3 = CfgIdxW'(3);

  localparam int SumBytes     = PayloadBytes - 4;
  localparam int DrainCycles  = 6;       // output register plus queue, with margin
  localparam int CycleLimit   = 200000;
  localparam int RandomBytes  = 640;
  localparam int RandomFrames = 12;

  // Fill patterns for the packet body.
  localparam int FillRandom = 0;
  localparam int FillOnes   = 1;
  localparam int FillZeros  = 2;

  typedef struct packed {
    logic        ok;
    logic [15:0] yaw;
    logic [15:0] throttle;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [7:0]  shutdown;
    logic [7:0]  hold_height;
    logic [7:0]  unlock;
  } frame_cmds_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the packet state machine and holds the command frames
  // that completed packets should produce, oldest first.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]      hdr_first;
    logic [7:0]      hdr_second;
    logic [PosW-1:0] pos;
    logic [SumW-1:0] sum;
    bit              hdr_ok;
    logic [31:0]     rx_sum;
    logic [7:0]      field_buf [FieldCount];
    frame_cmds_t     frames_due [$];
    int              errors;
    int              checked;
    int              ok_frames;

    function new();
      hdr_first  = HeaderFirstReset;
      hdr_second = HeaderSecondReset;
      pos        = '0;
      sum        = '0;
      hdr_ok     = 1'b1;
      rx_sum     = '0;
      errors     = 0;
      checked    = 0;
      ok_frames  = 0;
    endfunction

    function void set_header(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      if (idx == CfgHeaderFirst) hdr_first = val;
      else if (idx == CfgHeaderSecond) hdr_second = val;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Advances the packet state by one accepted byte.
    function void take_byte(logic [7:0] b, logic sop);
      logic [PosW-1:0] p;
      frame_cmds_t     r;
      if (sop) pos = '0;
      p = pos;
      // Byte zero always starts the sums over, whatever brought us there.
      if (p == PosHdr0) begin
        sum    = '0;
        hdr_ok = 1'b1;
        rx_sum = '0;
        if (b != hdr_first) hdr_ok = 1'b0;
      end else if (p == PosHdr1) begin
        if (b != hdr_second) hdr_ok = 1'b0;
      end
      if (p < PosSumEnd) sum = sum + SumW'(b);
      else rx_sum = {rx_sum[23:0], b};
      if (p >= PosFieldLo && p <= PosFieldHi) field_buf[p - PosFieldLo] = b;
      if (p == PosLast) begin
        r = '0;
        if (hdr_ok && rx_sum == 32'(sum)) begin
          r.ok          = 1'b1;
          r.yaw         = {field_buf[0], field_buf[1]};
          r.throttle    = {field_buf[2], field_buf[3]};
          r.pitch       = {field_buf[4], field_buf[5]};
          r.roll        = {field_buf[6], field_buf[7]};
          r.shutdown    = field_buf[8];
          r.hold_height = field_buf[9];
          r.unlock      = field_buf[10];
        end
        frames_due.push_back(r);
        pos = '0;
      end else begin
        pos = p + 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(frame_cmds_t got);
      frame_cmds_t want;
      if (frames_due.size() == 0) begin
        $error("result request with no packet pending: frame_ok=%0b", got.ok);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      checked++;
      if (got.ok === 1'b1) ok_frames++;
      compare_field("frame_ok", 16'(want.ok), 16'(got.ok));
      compare_field("yaw_cmd", want.yaw, got.yaw);
      compare_field("throttle_cmd", want.throttle, got.throttle);
      compare_field("pitch_cmd", want.pitch, got.pitch);
      compare_field("roll_cmd", want.roll, got.roll);
      compare_field("shutdown_cmd", 16'(want.shutdown), 16'(got.shutdown));
      compare_field("hold_height_cmd", 16'(want.hold_height), 16'(got.hold_height));
      compare_field("unlock_cmd", 16'(want.unlock), 16'(got.unlock));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i         = CfgHeaderFirst;
  logic [7:0]         cfg_wdata_i       = 8'h00;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i       = 8'h00;
  logic               start_of_packet_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic               frame_ok_o;
  logic [15:0]        yaw_cmd_o;
  logic [15:0]        throttle_cmd_o;
  logic [15:0]        pitch_cmd_o;
  logic [15:0]        roll_cmd_o;
  logic [7:0]         shutdown_cmd_o;
  logic [7:0]         hold_height_cmd_o;
  logic [7:0]         unlock_cmd_o;

  remote_frame_checker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .start_of_packet_i (start_of_packet_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_ok_o        (frame_ok_o),
    .yaw_cmd_o         (yaw_cmd_o),
    .throttle_cmd_o    (throttle_cmd_o),
    .pitch_cmd_o       (pitch_cmd_o),
    .roll_cmd_o        (roll_cmd_o),
    .shutdown_cmd_o    (shutdown_cmd_o),
    .hold_height_cmd_o (hold_height_cmd_o),
    .unlock_cmd_o      (unlock_cmd_o)
  );

  frame_scoreboard sb;
  logic [7:0]      frame_buf [PayloadBytes];
  bit              quiet        = 1'b0;   // set for stretches with no idling at all
  int              total_bytes  = 0;
  int              settings     = 1;      // reset values count as the first setting
  int              cycle_count  = 0;

  always #2 clk_i = ~clk_i;

  // The receiver stalls with a chance of about 22 in a hundred unless the run is quiet.
  always @(posedge clk_i) begin
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // Outputs are sampled at the edge, before the block's registers move, so a
  // result counts exactly when valid and ready are both high at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.match_result({frame_ok_o, yaw_cmd_o, throttle_cmd_o, pitch_cmd_o, roll_cmd_o,
                       shutdown_cmd_o, hold_height_cmd_o, unlock_cmd_o});
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Sends one byte request. Valid is only dropped when a gap is wanted, so a
  // back-to-back byte never sees valid lowered and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input logic sop);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 22) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= b;
    start_of_packet_i <= sop;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_byte(b, sop);
    total_bytes++;
  endtask

  // Holds the sender off until every pending result has come out, then lets
  // the pipeline settle so the block is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes both header registers, plus the two unused indexes, which the
  // block must ignore. Only called while the block is idle.
  task automatic write_headers(input logic [7:0] h0, input logic [7:0] h1);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgHeaderFirst;
    cfg_wdata_i <= h0;
    @(posedge clk_i);
    cfg_idx_i   <= CfgUnused2;
    cfg_wdata_i <= ~h0;
    @(posedge clk_i);
    cfg_idx_i   <= CfgHeaderSecond;
    cfg_wdata_i <= h1;
    @(posedge clk_i);
    cfg_idx_i   <= CfgUnused3;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_header(CfgHeaderFirst, h0);
    sb.set_header(CfgUnused2, ~h0);
    sb.set_header(CfgHeaderSecond, h1);
    sb.set_header(CfgUnused3, junk);
    settings++;
  endtask

  // Fills frame_buf with a well-formed packet: header, body, and the
  // big-endian sum of everything before the checksum bytes.
  function automatic void build_frame(logic [7:0] h0, logic [7:0] h1, int fill);
    logic [31:0] s;
    frame_buf[0] = h0;
    frame_buf[1] = h1;
    for (int i = 2; i < SumBytes; i++) begin
      case (fill)
        FillOnes:  frame_buf[i] = 8'hFF;
        FillZeros: frame_buf[i] = 8'h00;
        default:   frame_buf[i] = 8'($urandom);
      endcase
    end
    s = '0;
    for (int i = 0; i < SumBytes; i++) s = s + 32'(frame_buf[i]);
    for (int i = 0; i < 4; i++) frame_buf[SumBytes + i] = s[31 - 8*i -: 8];
  endfunction

  // Sends the first len bytes of frame_buf; a short len leaves the packet
  // unfinished so that the next start flag drops it.
  task automatic send_frame(input int len, input bit sop_first);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i], sop_first && i == 0);
  endtask

  function automatic logic [7:0] pick_header();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] h0;
    logic [7:0] h1;
    int         kind;
    int         fill;
    int         phase;
    int         phase_bytes;
    int         pkt;
    int         random_start_bytes;
    int         random_start_frames;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset header values. A packet with the largest
    // possible body sum comes first, then one that follows the final byte
    // with no start flag.
    build_frame(HeaderFirstReset, HeaderSecondReset, FillOnes);
    send_frame(PayloadBytes, 1'b1);
    build_frame(HeaderFirstReset, HeaderSecondReset, FillRandom);
    send_frame(PayloadBytes, 1'b0);
    // Wrong first header byte, then wrong second header byte.
    build_frame(HeaderFirstReset ^ 8'h01, HeaderSecondReset, FillRandom);
    send_frame(PayloadBytes, 1'b1);
    build_frame(HeaderFirstReset, HeaderSecondReset ^ 8'h80, FillRandom);
    send_frame(PayloadBytes, 1'b1);
    // Checksum with bits above the 14-bit sum range set never matches.
    build_frame(HeaderFirstReset, HeaderSecondReset, FillRandom);
    frame_buf[SumBytes] = 8'h80;
    send_frame(PayloadBytes, 1'b1);
    // A start flag mid-packet, including on what would be the last byte,
    // drops the packet in progress without a result.
    build_frame(HeaderFirstReset, HeaderSecondReset, FillRandom);
    send_frame(10, 1'b1);
    send_frame(PayloadBytes - 1, 1'b1);
    send_frame(PayloadBytes, 1'b1);
    drain_results();

    // Header extremes: all-zero packet is valid under zero headers, and a
    // packet with the old headers now fails.
    write_headers(8'h00, 8'h00);
    build_frame(8'h00, 8'h00, FillZeros);
    send_frame(PayloadBytes, 1'b1);
    build_frame(HeaderFirstReset, HeaderSecondReset, FillOnes);
    send_frame(PayloadBytes, 1'b1);
    drain_results();
    write_headers(8'hFF, 8'hFF);
    build_frame(8'hFF, 8'hFF, FillOnes);
    send_frame(PayloadBytes, 1'b1);
    build_frame(8'hFF, 8'hFF, FillZeros);
    send_frame(PayloadBytes, 1'b0);
    drain_results();

    // Random part: phases of mostly well-formed packets with random content,
    // each under its own header setting, with broken packets and byte noise.
    random_start_bytes  = total_bytes;
    random_start_frames = sb.checked;
    phase = 0;
    while (total_bytes - random_start_bytes < RandomBytes ||
           sb.checked - random_start_frames < RandomFrames) begin
      h0 = pick_header();
      h1 = pick_header();
      write_headers(h0, h1);
      quiet       = (phase == 2);
      phase_bytes = total_bytes;
      pkt         = 0;
      while (total_bytes - phase_bytes < 160) begin
        kind = $urandom_range(99);
        fill = ($urandom_range(9) == 0) ? FillOnes :
               ($urandom_range(9) == 0) ? FillZeros : FillRandom;
        build_frame(h0, h1, fill);
        if (kind < 60) begin
          send_frame(PayloadBytes, $urandom_range(4) != 0);
        end else if (kind < 70) begin
          frame_buf[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
          send_frame(PayloadBytes, 1'b1);
        end else if (kind < 80) begin
          frame_buf[$urandom_range(PayloadBytes - 1, 2)] ^= 8'(1 << $urandom_range(7));
          send_frame(PayloadBytes, 1'b1);
        end else if (kind < 90) begin
          send_frame($urandom_range(PayloadBytes - 1, 1), 1'b1);
        end else begin
          repeat ($urandom_range(8, 1)) send_byte(8'($urandom), 1'($urandom));
        end
        // Once per phase the sender stops until the results have caught up.
        if (pkt == 2) drain_results();
        pkt++;
      end
      drain_results();
      phase++;
    end

    quiet = 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d packet results never arrived", sb.pending());
      sb.errors++;
    end

    $display("Sent %0d bytes under %0d header settings, with gaps, stalls and dropped packets.",
             total_bytes, settings);
    $display("Checked %0d results: %0d valid frames, %0d rejected.",
             sb.checked, sb.ok_frames, sb.checked - sb.ok_frames);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
